@@ sv/fbsm_pkg.sv @@
// Shared types and codes for the frame buffer swap manager.
// Used by the engine and the top level; no dependencies.
`default_nettype none

package fbsm_pkg;

   // Buffer life cycle
   typedef enum logic [1:0] {
      ST_FREE    = 2'd0,
      ST_FILLING = 2'd1,
      ST_READY   = 2'd2,
      ST_IN_USE  = 2'd3
   } status_type;

   // Request kinds; the fourth code is ignored
   typedef enum logic [1:0] {
      KIND_CLAIM   = 2'd0,
      KIND_PUBLISH = 2'd1,
      KIND_FRAME   = 2'd2
   } kind_type;

   // Frame start outcome
   typedef enum logic [1:0] {
      OUT_SWAP   = 2'd0,
      OUT_REPEAT = 2'd1,
      OUT_BLANK  = 2'd2,
      OUT_NONE   = 2'd3
   } outcome_type;

   localparam int SEQ_W = 32;
   localparam int CNT_W = 32;

   // One request as held in the input register
   typedef struct packed {
      logic [1:0]       kind;
      logic             buffer;
      logic [SEQ_W-1:0] sequence_req;
   } item_type;

   // One result as held in the output register
   typedef struct packed {
      logic             accepted;
      logic             granted_buffer;
      outcome_type      frame_outcome;
      logic             shown_valid;
      logic             shown_buffer;
      logic [SEQ_W-1:0] shown_sequence;
      logic [CNT_W-1:0] frame_count;
      logic [CNT_W-1:0] swap_count;
      logic [CNT_W-1:0] repeat_count;
      logic [CNT_W-1:0] blank_count;
   } result_type;

endpackage

`default_nettype wire

@@ sv/fbsm_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Standalone; field widths match fbsm_pkg.
`default_nettype none

interface fbsm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        buffer;
   logic [31:0] sequence_req;

   modport source (output valid, kind, buffer, sequence_req, input ready);
   modport sink   (input valid, kind, buffer, sequence_req, output ready);
endinterface

interface fbsm_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        granted_buffer;
   logic [1:0]  frame_outcome;
   logic        shown_valid;
   logic        shown_buffer;
   logic [31:0] shown_sequence;
   logic [31:0] frame_count;
   logic [31:0] swap_count;
   logic [31:0] repeat_count;
   logic [31:0] blank_count;

   modport source (output valid, accepted, granted_buffer, frame_outcome, shown_valid,
                   shown_buffer, shown_sequence, frame_count, swap_count, repeat_count,
                   blank_count, input ready);
   modport sink   (input valid, accepted, granted_buffer, frame_outcome, shown_valid,
                   shown_buffer, shown_sequence, frame_count, swap_count, repeat_count,
                   blank_count, output ready);
endinterface

`default_nettype wire

@@ sv/fbsm_engine.sv @@
// Buffer pool state and per-request update logic.
// Depends on fbsm_pkg.
`default_nettype none

module fbsm_engine #(
   parameter int BUFFERS = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  fbsm_pkg::item_type    item,
   output fbsm_pkg::result_type  result
);
   import fbsm_pkg::*;

   localparam int IDX_W = $clog2(BUFFERS);

   // Pool state
   status_type       status_ff [BUFFERS];
   status_type       status_in [BUFFERS];
   logic [SEQ_W-1:0] seq_ff    [BUFFERS];
   logic [SEQ_W-1:0] seq_in    [BUFFERS];
   logic             shown_valid_ff, shown_valid_in;
   logic [IDX_W-1:0] shown_idx_ff, shown_idx_in;
   logic [SEQ_W-1:0] shown_seq_ff, shown_seq_in;
   logic [CNT_W-1:0] frame_cnt_ff, frame_cnt_in;
   logic [CNT_W-1:0] swap_cnt_ff, swap_cnt_in;
   logic [CNT_W-1:0] repeat_cnt_ff, repeat_cnt_in;
   logic [CNT_W-1:0] blank_cnt_ff, blank_cnt_in;

   // Search results
   logic             free_hit, ready_hit, pick_hit;
   logic [IDX_W-1:0] free_idx, ready_idx, pick_idx, pub_idx, grant_idx;
   logic [SEQ_W-1:0] pick_seq;
   logic             accepted;
   outcome_type      outcome;

   // Lowest free / lowest ready: scan downward so the lowest wins
   always_comb begin
      free_hit  = 1'b0;
      free_idx  = '0;
      ready_hit = 1'b0;
      ready_idx = '0;
      for (int i = BUFFERS - 1; i >= 0; i--) begin
         if (status_ff[i] == ST_FREE) begin
            free_hit = 1'b1;
            free_idx = IDX_W'(i);
         end
         if (status_ff[i] == ST_READY) begin
            ready_hit = 1'b1;
            ready_idx = IDX_W'(i);
         end
      end
   end

   // Newest ready frame; ties go to the higher index
   always_comb begin
      pick_hit = 1'b0;
      pick_idx = '0;
      pick_seq = '0;
      for (int i = 0; i < BUFFERS; i++) begin
         if (status_ff[i] == ST_READY && (!pick_hit || seq_ff[i] >= pick_seq)) begin
            pick_hit = 1'b1;
            pick_idx = IDX_W'(i);
            pick_seq = seq_ff[i];
         end
      end
   end

   assign pub_idx = IDX_W'(item.buffer);

   // Next state and result
   always_comb begin
      status_in      = status_ff;
      seq_in         = seq_ff;
      shown_valid_in = shown_valid_ff;
      shown_idx_in   = shown_idx_ff;
      shown_seq_in   = shown_seq_ff;
      frame_cnt_in   = frame_cnt_ff;
      swap_cnt_in    = swap_cnt_ff;
      repeat_cnt_in  = repeat_cnt_ff;
      blank_cnt_in   = blank_cnt_ff;
      accepted       = 1'b0;
      grant_idx      = '0;
      outcome        = OUT_NONE;
      case (kind_type'(item.kind))
         KIND_CLAIM: begin
            // a ready buffer is only taken when nothing is free
            if (free_hit) begin
               grant_idx = free_idx;
            end else begin
               grant_idx = ready_idx;
            end
            if (free_hit || ready_hit) begin
               status_in[grant_idx] = ST_FILLING;
               accepted             = 1'b1;
            end else begin
               grant_idx = '0;
            end
         end
         KIND_PUBLISH: begin
            if (status_ff[pub_idx] == ST_FILLING) begin
               status_in[pub_idx] = ST_READY;
               seq_in[pub_idx]    = item.sequence_req;
               accepted           = 1'b1;
            end
         end
         KIND_FRAME: begin
            accepted     = 1'b1;
            frame_cnt_in = frame_cnt_ff + 1'b1;
            if (pick_hit) begin
               if (shown_valid_ff && shown_idx_ff != pick_idx) begin
                  status_in[shown_idx_ff] = ST_FREE;
               end
               status_in[pick_idx] = ST_IN_USE;
               shown_valid_in      = 1'b1;
               shown_idx_in        = pick_idx;
               shown_seq_in        = pick_seq;
               swap_cnt_in         = swap_cnt_ff + 1'b1;
               outcome             = OUT_SWAP;
            end else if (shown_valid_ff) begin
               repeat_cnt_in = repeat_cnt_ff + 1'b1;
               outcome       = OUT_REPEAT;
            end else begin
               blank_cnt_in = blank_cnt_ff + 1'b1;
               outcome      = OUT_BLANK;
            end
         end
         default: begin
            outcome = OUT_NONE;
         end
      endcase
   end

   // Result reflects state after the update
   always_comb begin
      result.accepted       = accepted;
      result.granted_buffer = grant_idx[0];
      result.frame_outcome  = outcome;
      result.shown_valid    = shown_valid_in;
      result.shown_buffer   = shown_idx_in[0];
      result.shown_sequence = shown_seq_in;
      result.frame_count    = frame_cnt_in;
      result.swap_count     = swap_cnt_in;
      result.repeat_count   = repeat_cnt_in;
      result.blank_count    = blank_cnt_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUFFERS; i++) begin
            status_ff[i] <= ST_FREE;
         end
         shown_valid_ff <= 1'b0;
         shown_idx_ff   <= '0;
         shown_seq_ff   <= '0;
         frame_cnt_ff   <= '0;
         swap_cnt_ff    <= '0;
         repeat_cnt_ff  <= '0;
         blank_cnt_ff   <= '0;
      end else if (step) begin
         status_ff      <= status_in;
         shown_valid_ff <= shown_valid_in;
         shown_idx_ff   <= shown_idx_in;
         shown_seq_ff   <= shown_seq_in;
         frame_cnt_ff   <= frame_cnt_in;
         swap_cnt_ff    <= swap_cnt_in;
         repeat_cnt_ff  <= repeat_cnt_in;
         blank_cnt_ff   <= blank_cnt_in;
      end
   end

   // Stored sequences are only read while a buffer is ready
   always_ff @(posedge clock) begin
      if (step) begin
         seq_ff <= seq_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/frame_buffer_swap_manager_core.sv @@
// Frame buffer swap manager: input register, engine, output register.
// Depends on fbsm_pkg, fbsm_if and fbsm_engine.
`default_nettype none

// Tracks a pool of BUFFERS frame buffers shared by a producer and a display.
// Each request (claim, publish or frame start) gives exactly one response
// carrying the grant or outcome plus the display state and the four wrapping
// counters after that request. Throughput is one request per clock while the
// response side keeps up. A transferred request waits in the input register
// until the output register is free or being read out; the pool update then
// loads its response into the output register. The pool update is one pass of
// compare logic over all buffers, so the newest-frame search grows linearly in
// depth with BUFFERS. Both sides may stall freely; the output register holds a
// finished response while the next request is taken.
module frame_buffer_swap_manager_core #(
   parameter int BUFFERS = 2
) (
   input  logic       clock,
   input  logic       reset,
   fbsm_req_if.sink   req_chan,
   fbsm_rsp_if.source rsp_chan
);
   import fbsm_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   result_type result;
   logic       out_load;
   logic       req_xfer;

   // Pipeline handshake
   assign out_load       = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || out_load;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_xfer || (s1_valid_ff && !out_load);
   assign out_valid_in   = out_load || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff.kind         <= req_chan.kind;
         s1_item_ff.buffer       <= req_chan.buffer;
         s1_item_ff.sequence_req <= req_chan.sequence_req;
      end
   end

   fbsm_engine #(
      .BUFFERS (BUFFERS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (out_load),
      .item   (s1_item_ff),
      .result (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.accepted       = out_data_ff.accepted;
   assign rsp_chan.granted_buffer = out_data_ff.granted_buffer;
   assign rsp_chan.frame_outcome  = out_data_ff.frame_outcome;
   assign rsp_chan.shown_valid    = out_data_ff.shown_valid;
   assign rsp_chan.shown_buffer   = out_data_ff.shown_buffer;
   assign rsp_chan.shown_sequence = out_data_ff.shown_sequence;
   assign rsp_chan.frame_count    = out_data_ff.frame_count;
   assign rsp_chan.swap_count     = out_data_ff.swap_count;
   assign rsp_chan.repeat_count   = out_data_ff.repeat_count;
   assign rsp_chan.blank_count    = out_data_ff.blank_count;

   // A transfer in always leaves an item in the input register
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("request transfer lost before input register");

   // A swap means something is on display from then on
   a_swap_shown: assert property (@(posedge clock) disable iff (reset)
      out_load && result.frame_outcome == OUT_SWAP |=> rsp_chan.shown_valid)
      else $error("swap without a shown buffer");

   // Once shown, the display never goes back to nothing
   a_shown_sticky: assert property (@(posedge clock) disable iff (reset)
      out_load && out_valid_ff && out_data_ff.shown_valid |=> rsp_chan.shown_valid)
      else $error("shown_valid dropped");

endmodule

`default_nettype wire

@@ tb/fbsm_checker.sv @@
`timescale 1ns / 100ps
// Response checker for the frame buffer swap manager: watches both channels,
// predicts every response from its own copy of the buffer pool and compares.
// Depends on fbsm_pkg and the channel interfaces in fbsm_if.
module fbsm_checker
   import fbsm_pkg::*;
#(
   parameter int POOL_SIZE = 2
) (
   input  logic        clock,
   input  logic        reset,
   fbsm_req_if         req_mon,
   fbsm_rsp_if         rsp_mon,
   output int unsigned fault_count,
   output int unsigned pending_count,
   output int unsigned checked_count
);

   // Shadow of the pool and the display side
   status_type       slot_state [POOL_SIZE];
   logic [SEQ_W-1:0] slot_seq [POOL_SIZE];
   logic             display_on;
   int               display_idx;
   logic [SEQ_W-1:0] display_seq;
   logic [CNT_W-1:0] frames, swaps, repeats, blanks;

   // Responses predicted but not yet seen, oldest first
   result_type pending_responses [$];

   task automatic clear_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         slot_state[i] = ST_FREE;
         slot_seq[i]   = '0;
      end
      display_on  = 1'b0;
      display_idx = 0;
      display_seq = '0;
      frames      = '0;
      swaps       = '0;
      repeats     = '0;
      blanks      = '0;
   endtask

   // Apply one request to the shadow pool and build the response it yields
   task automatic apply_request(input logic [1:0] kind, input logic target,
                                input logic [SEQ_W-1:0] seq, output result_type res);
      int               pick;
      logic [SEQ_W-1:0] best;
      res = '0;
      res.frame_outcome = OUT_NONE;
      pick = -1;
      best = '0;
      case (kind)
         KIND_CLAIM: begin
            // lowest free buffer, else lowest ready one (its frame is dropped)
            for (int i = POOL_SIZE - 1; i >= 0; i--)
               if (slot_state[i] == ST_FREE) pick = i;
            if (pick < 0)
               for (int i = POOL_SIZE - 1; i >= 0; i--)
                  if (slot_state[i] == ST_READY) pick = i;
            if (pick >= 0) begin
               slot_state[pick]   = ST_FILLING;
               res.accepted       = 1'b1;
               res.granted_buffer = pick[0];
            end
         end
         KIND_PUBLISH: begin
            if (slot_state[target] == ST_FILLING) begin
               slot_seq[target]   = seq;
               slot_state[target] = ST_READY;
               res.accepted       = 1'b1;
            end
         end
         KIND_FRAME: begin
            res.accepted = 1'b1;
            frames = frames + 1'b1;
            // newest ready frame; equal sequences go to the higher index
            for (int i = 0; i < POOL_SIZE; i++)
               if (slot_state[i] == ST_READY && (pick < 0 || slot_seq[i] >= best)) begin
                  pick = i;
                  best = slot_seq[i];
               end
            if (pick < 0) begin
               if (display_on) begin
                  repeats = repeats + 1'b1;
                  res.frame_outcome = OUT_REPEAT;
               end else begin
                  blanks = blanks + 1'b1;
                  res.frame_outcome = OUT_BLANK;
               end
            end else begin
               if (display_on && display_idx != pick)
                  slot_state[display_idx] = ST_FREE;
               slot_state[pick] = ST_IN_USE;
               display_on  = 1'b1;
               display_idx = pick;
               display_seq = best;
               swaps = swaps + 1'b1;
               res.frame_outcome = OUT_SWAP;
            end
         end
         default: ;  // unused kind: no effect
      endcase
      res.shown_valid    = display_on;
      res.shown_buffer   = display_idx[0];
      res.shown_sequence = display_seq;
      res.frame_count    = frames;
      res.swap_count     = swaps;
      res.repeat_count   = repeats;
      res.blank_count    = blanks;
   endtask

   task automatic report_fault(input string msg);
      fault_count = fault_count + 1;
      $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] seen,
                              input logic [31:0] wanted);
      if (seen !== wanted)
         report_fault($sformatf("%s got %0h expected %0h", name, seen, wanted));
   endtask

   // Predict on request transfers, compare on response transfers
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_pool();
         pending_responses.delete();
         fault_count = 0;
         pending_count <= 0;
         checked_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            apply_request(req_mon.kind, req_mon.buffer, req_mon.sequence_req, want);
            pending_responses.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_responses.size() == 0) begin
               report_fault("response transfer with no request outstanding");
            end else begin
               want = pending_responses.pop_front();
               check_field("accepted", rsp_mon.accepted, want.accepted);
               check_field("granted_buffer", rsp_mon.granted_buffer, want.granted_buffer);
               check_field("frame_outcome", rsp_mon.frame_outcome, want.frame_outcome);
               check_field("shown_valid", rsp_mon.shown_valid, want.shown_valid);
               check_field("shown_buffer", rsp_mon.shown_buffer, want.shown_buffer);
               check_field("shown_sequence", rsp_mon.shown_sequence, want.shown_sequence);
               check_field("frame_count", rsp_mon.frame_count, want.frame_count);
               check_field("swap_count", rsp_mon.swap_count, want.swap_count);
               check_field("repeat_count", rsp_mon.repeat_count, want.repeat_count);
               check_field("blank_count", rsp_mon.blank_count, want.blank_count);
               checked_count <= checked_count + 1;
            end
         end
         pending_count <= pending_responses.size();
      end
   end

endmodule

@@ tb/frame_buffer_swap_manager_core_test.sv @@
`timescale 1ns / 100ps
// Top of the frame buffer swap manager testbench: clock, reset, request and
// response drivers with random stalls, watchdog and verdict.
// Depends on fbsm_pkg, fbsm_if, the core and fbsm_checker.
module frame_buffer_swap_manager_core_test;
   import fbsm_pkg::*;

   localparam int POOL_SIZE    = 2;
   localparam int RANDOM_ITEMS = 1500;
   localparam int IDLE_LIMIT   = 2000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;

   fbsm_req_if req_chan ();
   fbsm_rsp_if rsp_chan ();

   int unsigned fault_total, pending_total, checked_total;
   int unsigned idle_cycles = 0;
   int unsigned claims_sent = 0, publishes_sent = 0, frames_sent = 0, ignored_sent = 0;
   bit          send_burst = 1'b0;
   bit          rsp_hold_request = 1'b0;
   logic [31:0] last_seq;

   always #5 clock = ~clock;

   frame_buffer_swap_manager_core #(.BUFFERS(POOL_SIZE)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   fbsm_checker #(.POOL_SIZE(POOL_SIZE)) response_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fault_count   (fault_total),
      .pending_count (pending_total),
      .checked_count (checked_total)
   );

   // Offer one request after a random gap and hold it until its transfer
   task automatic send_item(input logic [1:0] kind, input logic target,
                            input logic [31:0] seq, input bit no_gap);
      int gap;
      gap = (no_gap || send_burst) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.kind         <= kind;
      req_chan.buffer       <= target;
      req_chan.sequence_req <= seq;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      case (kind)
         KIND_CLAIM:   claims_sent++;
         KIND_PUBLISH: publishes_sent++;
         KIND_FRAME:   frames_sent++;
         default:      ignored_sent++;
      endcase
   endtask

   // Response side: random stalls, burst stretches, one long hold-off on request
   initial begin
      int stall;
      bit rsp_burst;
      rsp_burst = 1'b0;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 63) == 0) rsp_burst = !rsp_burst;
         if (rsp_hold_request) begin
            stall = LONG_HOLD;
            rsp_hold_request = 1'b0;
         end else begin
            stall = rsp_burst ? 0 : $urandom_range(0, 6);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // Watchdog: stretch of cycles without any transfer
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] Watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      int unsigned counted;
      int          roll;
      logic [1:0]  kind;
      logic        target;
      logic [31:0] seq;
      bit          pressure_done;
      bit          drain_done;

      counted       = 0;
      pressure_done = 1'b0;
      drain_done    = 1'b0;
      last_seq      = $urandom();
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.kind         <= KIND_CLAIM;
      req_chan.buffer       <= 1'b0;
      req_chan.sequence_req <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through the pool states
      send_item(KIND_FRAME,   1'b0, 32'h0000_0000, 1'b0);  // nothing shown yet: blank
      send_item(KIND_UNUSED,  1'b0, 32'h0000_0000, 1'b0);  // ignored kind
      send_item(KIND_PUBLISH, 1'b0, 32'h0000_0001, 1'b0);  // buffer still free: refused
      send_item(KIND_CLAIM,   1'b0, 32'h0000_0000, 1'b0);  // gets buffer 0
      send_item(KIND_CLAIM,   1'b1, 32'h0000_0000, 1'b0);  // gets buffer 1
      send_item(KIND_CLAIM,   1'b0, 32'h0000_0000, 1'b0);  // pool exhausted: refused
      send_item(KIND_PUBLISH, 1'b1, 32'h0000_0007, 1'b0);
      send_item(KIND_PUBLISH, 1'b0, 32'h0000_0007, 1'b0);  // equal sequences
      send_item(KIND_PUBLISH, 1'b0, 32'h0000_0009, 1'b0);  // already ready: refused
      send_item(KIND_FRAME,   1'b0, 32'h0000_0000, 1'b0);  // tie goes to buffer 1
      send_item(KIND_CLAIM,   1'b0, 32'h0000_0000, 1'b0);  // none free: stale buffer 0 reused
      send_item(KIND_FRAME,   1'b0, 32'h0000_0000, 1'b0);  // nothing ready: repeat
      send_item(KIND_PUBLISH, 1'b0, 32'hFFFF_FFFF, 1'b0);
      send_item(KIND_FRAME,   1'b1, 32'hFFFF_FFFF, 1'b0);  // swap, frees buffer 1
      send_item(KIND_CLAIM,   1'b1, 32'h0000_0000, 1'b0);
      send_item(KIND_PUBLISH, 1'b1, 32'h0000_0000, 1'b0);  // older sequence still wins alone
      send_item(KIND_FRAME,   1'b0, 32'h0000_0000, 1'b0);
      send_item(KIND_PUBLISH, 1'b1, 32'h1234_5678, 1'b0);  // buffer in use: refused
      send_item(KIND_UNUSED,  1'b1, 32'hFFFF_FFFF, 1'b0);
      send_item(KIND_CLAIM,   1'b0, 32'h0000_0000, 1'b0);
      send_item(KIND_PUBLISH, 1'b0, 32'h8000_0000, 1'b0);
      send_item(KIND_FRAME,   1'b1, 32'h5555_AAAA, 1'b0);

      // Random traffic, mostly rising sequence numbers with occasional ties
      while (counted < RANDOM_ITEMS) begin
         if (counted % 150 == 0) send_burst = ($urandom_range(0, 3) == 0);

         // response side stalls long while requests keep coming
         if (counted >= 500 && !pressure_done) begin
            pressure_done = 1'b1;
            rsp_hold_request = 1'b1;
            repeat (12) begin
               kind = ($urandom_range(0, 1) != 0) ? KIND_CLAIM : KIND_FRAME;
               send_item(kind, 1'($urandom_range(0, 1)), $urandom(), 1'b1);
               counted++;
            end
         end

         // let everything in flight come back before carrying on
         if (counted >= 1000 && !drain_done) begin
            drain_done = 1'b1;
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (pending_total != 0);
         end

         roll   = $urandom_range(0, 99);
         target = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0:       seq = $urandom();
            1:       seq = last_seq;
            default: begin
               last_seq = last_seq + $urandom_range(1, 3);
               seq = last_seq;
            end
         endcase
         if (roll < 30)      kind = KIND_CLAIM;
         else if (roll < 65) kind = KIND_PUBLISH;
         else if (roll < 96) kind = KIND_FRAME;
         else                kind = KIND_UNUSED;
         send_item(kind, target, seq, 1'b0);
         if (kind != KIND_UNUSED) counted++;
      end

      // Wait out every outstanding response, then a quiet drain period
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_total != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d claims, %0d publishes, %0d frame starts, %0d ignored requests;",
               claims_sent, publishes_sent, frames_sent, ignored_sent);
      $display("%0d responses compared, with a %0d-cycle response hold-off and a mid-run drain.",
               checked_total, LONG_HOLD);
      if (fault_total == 0 && pending_total == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
